// ===== rtl/pclms_pkg.sv =====
// ----------------------------------------------------------------------------
// pclms_pkg
// Shared types and constants for the layered minimum-range scan block.
// ----------------------------------------------------------------------------
package pclms_pkg;

	localparam int CFG_W = 13;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_OFFSET_X     = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET_Z     = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROBOT_HEIGHT = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_HEIGHT   = 3'd3;
	localparam logic [IDX_W-1:0] REG_BINS_BELOW   = 3'd4;
	localparam logic [IDX_W-1:0] REG_BINS_ABOVE   = 3'd5;
	localparam logic [IDX_W-1:0] REG_COLUMNS      = 3'd6;
	localparam logic [IDX_W-1:0] REG_NULL_HEIGHT  = 3'd7;

	localparam logic signed [12:0] RST_OFFSET_X     = 13'sd0;
	localparam logic signed [12:0] RST_OFFSET_Z     = 13'sd0;
	localparam logic [11:0]        RST_ROBOT_HEIGHT = 12'd400;
	localparam logic [11:0]        RST_MAX_HEIGHT   = 12'd1200;
	localparam logic [2:0]         RST_BINS_BELOW   = 3'd1;
	localparam logic [2:0]         RST_BINS_ABOVE   = 3'd1;
	localparam logic [10:0]        RST_COLUMNS      = 11'd640;
	localparam logic signed [12:0] RST_NULL_HEIGHT  = -13'sd1000;

	localparam int MIN_X    = 50;
	localparam int MIN_Z    = 40;
	localparam int MAX_JUMP = 100;
	localparam int Z_MAX    = 4095;
	localparam int Z_MIN    = -4096;

	// Shared divider: numerator and denominator widths.
	localparam int DIV_NW = 16;
	localparam int DIV_DW = 12;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_PDIV,
		ST_PRD,
		ST_PUPD,
		ST_RRD,
		ST_RDIV,
		ST_RFIN
	} state_t;

	typedef struct packed {
		logic take;
		logic clr_step;
		logic div_start;
		logic bin_load;
		logic ram_rd;
		logic upd_wr;
		logic rd_fin;
	} cmd_t;

	typedef struct packed {
		logic req_read;
		logic drop;
		logic div_done;
		logic clr_last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/pclms_ram.sv =====
// ----------------------------------------------------------------------------
// pclms_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pclms_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/pclms_div.sv =====
// ----------------------------------------------------------------------------
// pclms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pclms_div
	import pclms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW:0]   rem_sh;
	logic              qbit;
	logic [DIV_DW:0]   rem_nx;

	always_comb begin
		rem_sh = {rem_q, num_q[DIV_NW-1]};
		qbit   = (rem_sh >= {1'b0, den_q});
		rem_nx = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The quotient is shifted in where the numerator bits are shifted out.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-2:0], qbit};
			rem_q <= rem_nx[DIV_DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== rtl/pclms_dp.sv =====
// ----------------------------------------------------------------------------
// pclms_dp
// Datapath: configuration, point transform and filters, bin and cell
// addressing, cell memory, bin centre and result register.
// ----------------------------------------------------------------------------
module pclms_dp
	import pclms_pkg::*;
#(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_BINS    = 8,
	parameter int COORD_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output status_t                      st,
	input  logic                         cfg_write,
	input  logic [IDX_W-1:0]             cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         req_type,
	input  logic                         frame_start,
	input  logic                         point_valid,
	input  logic signed [15:0]           cam_x,
	input  logic signed [15:0]           cam_y,
	input  logic signed [15:0]           cam_z,
	input  logic [2:0]                   read_bin,
	input  logic [9:0]                   read_col,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic signed [12:0]           out_z,
	output logic                         cell_filled
);

	localparam int CB    = COORD_BITS;
	localparam int DEPTH = MAX_BINS * MAX_COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int MW    = 2 * CB + 1;
	localparam int CMAX  = 2 ** (CB - 1) - 1;
	localparam int CMIN  = -CMAX - 1;

	function automatic logic signed [CB-1:0] sat_c(input logic signed [17:0] v);
		int vi;
		vi = int'(v);
		if (vi > CMAX) begin
			vi = CMAX;
		end else if (vi < CMIN) begin
			vi = CMIN;
		end
		return CB'(vi);
	endfunction

	// Configuration registers.
	logic signed [12:0] offset_x_q, offset_z_q, null_height_q;
	logic [11:0]        rh_q, mh_q;
	logic [2:0]         bb_q, ba_q;
	logic [10:0]        columns_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q    <= RST_OFFSET_X;
			offset_z_q    <= RST_OFFSET_Z;
			rh_q          <= RST_ROBOT_HEIGHT;
			mh_q          <= RST_MAX_HEIGHT;
			bb_q          <= RST_BINS_BELOW;
			ba_q          <= RST_BINS_ABOVE;
			columns_q     <= RST_COLUMNS;
			null_height_q <= RST_NULL_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_OFFSET_X:     offset_x_q    <= cfg_data;
				REG_OFFSET_Z:     offset_z_q    <= cfg_data;
				REG_ROBOT_HEIGHT: rh_q          <= cfg_data[11:0];
				REG_MAX_HEIGHT:   mh_q          <= cfg_data[11:0];
				REG_BINS_BELOW:   bb_q          <= cfg_data[2:0];
				REG_BINS_ABOVE:   ba_q          <= cfg_data[2:0];
				REG_COLUMNS:      columns_q     <= cfg_data[10:0];
				REG_NULL_HEIGHT:  null_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective column and bin counts.
	int cols_e, bins_last;
	always_comb begin
		cols_e = int'(columns_q);
		if (cols_e == 0) begin
			cols_e = 1;
		end else if (cols_e > MAX_COLUMNS) begin
			cols_e = MAX_COLUMNS;
		end
		bins_last = int'(bb_q) + int'(ba_q);
		if (bins_last == 0) begin
			bins_last = 1;
		end else if (bins_last > MAX_BINS) begin
			bins_last = MAX_BINS;
		end
		bins_last = bins_last - 1;
	end

	// Point transform, filters and column step, all resolved at accept.
	logic signed [CB-1:0] px_x, px_y, px_z;
	logic                 known0, jump, drop_c;
	int                   dif, cc0, col_c, cc_nx;

	logic [CW-1:0]        cc_q;
	logic signed [CB-1:0] last_q;
	logic                 known_q;

	always_comb begin
		px_x   = sat_c(18'(cam_z) + 18'(offset_x_q));
		px_y   = sat_c(-18'(cam_x));
		px_z   = sat_c(-18'(cam_y) + 18'(offset_z_q));
		known0 = frame_start ? 1'b0 : known_q;
		dif    = int'(last_q) - int'(px_x);
		jump   = known0 && (dif > MAX_JUMP || dif < -MAX_JUMP);
		drop_c = !point_valid || int'(px_x) < MIN_X || int'(px_z) < MIN_Z ||
		         int'(px_z) >= int'(mh_q) || jump;
		cc0    = frame_start ? 0 : int'(cc_q);
		if (cc0 >= cols_e) begin
			cc0 = 0;
		end
		col_c = cols_e - 1 - cc0;
		cc_nx = cc0 + 1;
		if (cc_nx >= cols_e) begin
			cc_nx = 0;
		end
	end

	logic                 is_read_q, inrange_q;
	logic [2:0]           rbin_q;
	logic [AW-1:0]        addr_q;
	logic signed [CB-1:0] x_s1, y_s1, z_s1;
	logic                 drop_s1;
	logic [CW-1:0]        col_s1;
	int                   bin_c, cen_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q    <= '0;
			last_q  <= '0;
			known_q <= 1'b0;
		end else if (cmd.take && !req_type) begin
			cc_q    <= CW'(cc_nx);
			known_q <= point_valid;
			if (point_valid) begin
				last_q <= px_x;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			is_read_q <= req_type;
			rbin_q    <= read_bin;
			inrange_q <= (int'(read_bin) < MAX_BINS) && (int'(read_col) < MAX_COLUMNS);
			addr_q    <= AW'(int'(read_bin) * MAX_COLUMNS + int'(read_col));
			x_s1      <= px_x;
			y_s1      <= px_y;
			z_s1      <= px_z;
			drop_s1   <= drop_c;
			col_s1    <= CW'(col_c);
		end else if (cmd.bin_load) begin
			addr_q <= AW'(bin_c * MAX_COLUMNS + int'(col_s1));
		end
	end

	// Divider operands: bin index for a point, bin centre for a read.
	logic              up_c, lo_c;
	logic [DIV_NW-1:0] dnum;
	logic [DIV_DW-1:0] dden;
	logic              neg_c;
	int                mag;
	logic              lo_q, ba0_q, neg_q;

	always_comb begin
		up_c  = int'(z_s1) > int'(rh_q);
		lo_c  = int'(rbin_q) < int'(bb_q);
		neg_c = 1'b0;
		mag   = int'(mh_q) - int'(rh_q);
		if (mag < 0) begin
			mag   = -mag;
			neg_c = 1'b1;
		end
		if (!is_read_q) begin
			if (up_c) begin
				dnum = DIV_NW'(int'(ba_q) * (int'(z_s1) - int'(rh_q)));
				dden = DIV_DW'(int'(mh_q) - int'(rh_q));
			end else begin
				dnum = DIV_NW'(int'(bb_q) * int'(z_s1));
				dden = rh_q;
			end
		end else if (lo_c) begin
			dnum = DIV_NW'(int'(rh_q) * (2 * int'(rbin_q) + 1));
			dden = DIV_DW'(2 * int'(bb_q));
		end else if (ba_q == 3'd0) begin
			dnum = '0;
			dden = DIV_DW'(1);
		end else begin
			dnum = DIV_NW'(mag * (2 * (int'(rbin_q) - int'(bb_q)) + 1));
			dden = DIV_DW'(2 * int'(ba_q));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			lo_q  <= lo_c;
			ba0_q <= (ba_q == 3'd0);
			neg_q <= neg_c;
		end
	end

	logic              div_done;
	logic [DIV_NW-1:0] quot;

	pclms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dnum),
		.den    (dden),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		bin_c = up_c ? int'(bb_q) + int'(quot) : int'(quot);
		if (bin_c > bins_last) begin
			bin_c = bins_last;
		end
		if (lo_q) begin
			cen_c = int'(quot);
		end else if (ba0_q) begin
			cen_c = int'(rh_q);
		end else begin
			cen_c = int'(rh_q) + (neg_q ? -int'(quot) : int'(quot));
		end
		if (cen_c > Z_MAX) begin
			cen_c = Z_MAX;
		end else if (cen_c < Z_MIN) begin
			cen_c = Z_MIN;
		end
	end

	// Cell memory: {full, range, lateral}; the clearing pass zeroes it after reset.
	logic [AW-1:0] clr_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [MW-1:0] ram_wdata, ram_rdata;
	logic          cell_full;
	logic signed [CB-1:0] cell_rng, cell_lat;
	logic          upd_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		cell_full = ram_rdata[MW-1];
		cell_rng  = ram_rdata[2*CB-1:CB];
		cell_lat  = ram_rdata[CB-1:0];
		upd_ok    = !cell_full || (x_s1 < cell_rng);
		ram_we    = cmd.clr_step || (cmd.upd_wr && upd_ok) || (cmd.rd_fin && inrange_q);
		ram_waddr = cmd.clr_step ? clr_q : addr_q;
		ram_wdata = cmd.upd_wr ? {1'b1, x_s1, y_s1} : '0;
	end

	pclms_ram #(
		.WIDTH (MW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.ram_rd),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// Result register.
	logic fill_c;
	assign fill_c = inrange_q && cell_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.rd_fin) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_fin) begin
			out_x       <= fill_c ? cell_rng : '0;
			out_y       <= fill_c ? cell_lat : '0;
			out_z       <= fill_c ? 13'(cen_c) : null_height_q;
			cell_filled <= fill_c;
		end
	end

	always_comb begin
		st.req_read = req_type;
		st.drop     = drop_s1;
		st.div_done = div_done;
		st.clr_last = (clr_q == AW'(DEPTH - 1));
		st.out_free = !out_valid || out_ready;
	end

endmodule

// ===== rtl/pclms_ctrl.sv =====
// ----------------------------------------------------------------------------
// pclms_ctrl
// Controller: sequences the clearing pass, point updates and cell reads.
// ----------------------------------------------------------------------------
module pclms_ctrl
	import pclms_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_nx = st.req_read ? ST_RRD : ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (st.drop) begin
					state_nx = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = ST_PDIV;
				end
			end
			ST_PDIV: begin
				if (st.div_done) begin
					cmd.bin_load = 1'b1;
					state_nx     = ST_PRD;
				end
			end
			ST_PRD: begin
				cmd.ram_rd = 1'b1;
				state_nx   = ST_PUPD;
			end
			ST_PUPD: begin
				cmd.upd_wr = 1'b1;
				state_nx   = ST_IDLE;
			end
			ST_RRD: begin
				cmd.ram_rd    = 1'b1;
				cmd.div_start = 1'b1;
				state_nx      = ST_RDIV;
			end
			ST_RDIV: begin
				if (st.div_done) begin
					state_nx = ST_RFIN;
				end
			end
			ST_RFIN: begin
				if (st.out_free) begin
					cmd.rd_fin = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/point_cloud_layered_min_range_scan.sv =====
// ----------------------------------------------------------------------------
// point_cloud_layered_min_range_scan
// Builds a layered minimum-range scan from a camera point stream.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAX_BINS*MAX_COLUMNS cells of its cell
// memory clear (8192 at the defaults), one cell a cycle, before it takes a
// beat; configuration writes are taken throughout. It then handles one beat
// at a time. A dropped point goes back to idle after the filter check; a
// kept point waits on the shared radix-2 divider for its bin index, and a
// cell read waits on it for the bin centre and then for the result slot.
// A result waits in an output register, so a new beat is taken meanwhile.
module point_cloud_layered_min_range_scan
	import pclms_pkg::*;
#(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_BINS    = 8,
	parameter int COORD_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [IDX_W-1:0]             cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic                         frame_start,
	input  logic                         point_valid,
	input  logic signed [15:0]           cam_x,
	input  logic signed [15:0]           cam_y,
	input  logic signed [15:0]           cam_z,
	input  logic [2:0]                   read_bin,
	input  logic [9:0]                   read_col,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic signed [12:0]           out_z,
	output logic                         cell_filled
);

	cmd_t    cmd;
	status_t st;

	pclms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	pclms_dp #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_BINS    (MAX_BINS),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.frame_start (frame_start),
		.point_valid (point_valid),
		.cam_x       (cam_x),
		.cam_y       (cam_y),
		.cam_z       (cam_z),
		.read_bin    (read_bin),
		.read_col    (read_col),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.cell_filled (cell_filled)
	);

	// No beat is taken while the clearing pass runs.
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !in_ready)
		else $error("input taken during clearing pass");

	// A finished read always lands in the output register.
	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_fin |=> out_valid)
		else $error("read finished without a result");

	// The divider drops its done flag as soon as it is started.
	a_div_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !st.div_done)
		else $error("divider reported done right after start");

endmodule
